### rtl/core/kmnca_pkg.sv
// Shared types and constants for the k-means nearest-centre assignment block.
// Used by kmnca_cell and kmeans_nearest_center_assign_top; no dependencies.
`default_nettype none
package kmnca_pkg;

  localparam int MAX_CENTERS_DEF = 16;
  localparam int MAX_DIMS_DEF    = 16;
  localparam int COORD_BITS_DEF  = 16;

  localparam int IN_COORD_W = 16;
  localparam int IDX_W      = 4;
  localparam int NUM_W      = 5;
  localparam int DIST_W     = 36;
  localparam int CNT_W      = 32;
  localparam int OBJ_W      = 63;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_POINT = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef struct packed {
    logic wr;
    logic mul;
    logic acc;
    logic clr_part;
    logic clr_cnt;
    logic bump;
    logic chain;
  } cell_ctl_t;

endpackage
`default_nettype wire

### rtl/core/kmeans_nearest_center_assign_top.sv
// K-means assignment step: a chain of one cell per centre and a sequencer.
// Load and start transactions return straight to idle; a non-final coordinate passes the read,
// multiply and accumulate states. A final coordinate then walks the best-centre pair
// along the chain (search state), updates the totals and emits its result; a count
// readback goes straight to the emit state. A stalled result holds the input.
// Synchronous reset clears counts, distances and sets the centre count to 16.
`default_nettype none
module kmeans_nearest_center_assign_top #(
  parameter int MAX_CENTERS = kmnca_pkg::MAX_CENTERS_DEF,
  parameter int MAX_DIMS    = kmnca_pkg::MAX_DIMS_DEF,
  parameter int COORD_BITS  = kmnca_pkg::COORD_BITS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_we,
  input  wire [kmnca_pkg::NUM_W-1:0]           cfg_wdata,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire [1:0]                            op,
  input  wire [kmnca_pkg::IDX_W-1:0]           center_index,
  input  wire [kmnca_pkg::IDX_W-1:0]           dim_index,
  input  wire signed [kmnca_pkg::IN_COORD_W-1:0] coord_value,
  input  wire [kmnca_pkg::IDX_W-1:0]           prev_assignment,
  input  wire                                  last_coord,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic                                 result_kind,
  output logic [kmnca_pkg::IDX_W-1:0]          assignment,
  output logic                                 moved,
  output logic [kmnca_pkg::DIST_W-1:0]         distance,
  output logic [kmnca_pkg::CNT_W-1:0]          changed_total,
  output logic [kmnca_pkg::OBJ_W-1:0]          objective,
  output logic [kmnca_pkg::CNT_W-1:0]          cluster_size
);
  import kmnca_pkg::*;

  localparam int CW    = COORD_BITS;
  localparam int CA_W  = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
  localparam int DA_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int K_W   = $clog2(MAX_CENTERS + 1);
  localparam logic signed [32:0] LO = -(33'sd1 <<< (CW - 1));
  localparam logic signed [32:0] HI = (33'sd1 <<< (CW - 1)) - 33'sd1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD   = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_ACC  = 7'b0001000,
    S_SRCH = 7'b0010000,
    S_UPD  = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic [NUM_W-1:0]       num_centers;
  logic signed [CW-1:0]   coord_sat;
  logic signed [32:0]     coord_ext;
  logic signed [CW-1:0]   coord;
  logic                   dim_ok;
  logic                   ctr_ok;
  logic                   last;
  logic [IDX_W-1:0]       prev;
  logic [DA_W-1:0]        raddr;
  logic [K_W-1:0]         k;
  logic [CNT_W-1:0]       changed_cnt;
  logic [OBJ_W-1:0]       obj_sum;
  logic                   accept;
  logic                   out_free;
  cell_ctl_t              ctl;
  logic                   pend_kind;
  logic [IDX_W-1:0]       pend_asg;
  logic                   pend_moved;
  logic [DIST_W-1:0]      pend_dist;
  logic [CNT_W-1:0]       pend_chg;
  logic [OBJ_W-1:0]       pend_obj;
  logic [CNT_W-1:0]       pend_size;
  logic                   mv;
  logic [OBJ_W:0]         obj_add;

  logic [CA_W-1:0]        c_idx  [MAX_CENTERS];
  logic [DIST_W-1:0]      c_dist [MAX_CENTERS];
  logic [CNT_W-1:0]       c_cnt  [MAX_CENTERS];

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    coord_ext = 33'(coord_value);
    if (coord_ext < LO) begin
      coord_sat = CW'(LO);
    end else if (coord_ext > HI) begin
      coord_sat = CW'(HI);
    end else begin
      coord_sat = CW'(coord_ext);
    end
    ctr_ok = (7'(center_index) < 7'(MAX_CENTERS));
    mv     = (7'(c_idx[MAX_CENTERS-1]) != 7'(prev));
    obj_add = (OBJ_W+1)'(obj_sum) + (OBJ_W+1)'(c_dist[MAX_CENTERS-1]);
  end

  always_comb begin
    ctl = '0;
    ctl.wr       = accept && (op_t'(op) == OP_LOAD) && ctr_ok
                   && (7'(dim_index) < 7'(MAX_DIMS));
    ctl.clr_cnt  = accept && (op_t'(op) == OP_START);
    ctl.clr_part = ctl.clr_cnt || (state == S_UPD);
    ctl.mul      = (state == S_MUL);
    ctl.acc      = (state == S_ACC) && dim_ok;
    ctl.chain    = (state == S_SRCH);
    ctl.bump     = (state == S_UPD);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (op_t'(op))
            OP_POINT: state_next = S_RD;
            OP_READ:  state_next = S_EMIT;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_RD:   state_next = S_MUL;
      S_MUL:  state_next = S_ACC;
      S_ACC:  state_next = last ? S_SRCH : S_IDLE;
      S_SRCH: state_next = (k == K_W'(MAX_CENTERS - 1)) ? S_UPD : S_SRCH;
      S_UPD:  state_next = S_EMIT;
      S_EMIT: state_next = out_free ? S_IDLE : S_EMIT;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      num_centers <= NUM_W'(16);
      k <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        num_centers <= cfg_wdata;
      end
      k <= (state == S_SRCH) ? k + 1'b1 : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      coord  <= coord_sat;
      raddr  <= DA_W'(dim_index);
      dim_ok <= (7'(dim_index) < 7'(MAX_DIMS));
      last   <= last_coord;
      prev   <= prev_assignment;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clr_cnt) begin
      changed_cnt <= '0;
      obj_sum     <= '0;
    end else if (state == S_UPD) begin
      if (mv && (changed_cnt != {CNT_W{1'b1}})) begin
        changed_cnt <= changed_cnt + 1'b1;
      end
      obj_sum <= obj_add[OBJ_W] ? {OBJ_W{1'b1}} : obj_add[OBJ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (op_t'(op) == OP_READ)) begin
      pend_kind  <= 1'b1;
      pend_asg   <= '0;
      pend_moved <= 1'b0;
      pend_dist  <= '0;
      pend_chg   <= '0;
      pend_obj   <= '0;
      pend_size  <= ctr_ok ? c_cnt[CA_W'(center_index)] : '0;
    end else if (state == S_UPD) begin
      pend_kind  <= 1'b0;
      pend_asg   <= IDX_W'(c_idx[MAX_CENTERS-1]);
      pend_moved <= mv;
      pend_dist  <= c_dist[MAX_CENTERS-1];
      pend_chg   <= (mv && (changed_cnt != {CNT_W{1'b1}})) ? changed_cnt + 1'b1
                                                            : changed_cnt;
      pend_obj   <= obj_add[OBJ_W] ? {OBJ_W{1'b1}} : obj_add[OBJ_W-1:0];
      pend_size  <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_EMIT) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && out_free) begin
      result_kind   <= pend_kind;
      assignment    <= pend_asg;
      moved         <= pend_moved;
      distance      <= pend_dist;
      changed_total <= pend_chg;
      objective     <= pend_obj;
      cluster_size  <= pend_size;
    end
  end

  for (genvar g = 0; g < MAX_CENTERS; g++) begin : g_cell
    logic [CA_W-1:0]   idx_in;
    logic [DIST_W-1:0] dist_in;
    if (g == 0) begin : g_head
      assign idx_in  = '0;
      assign dist_in = '0;
    end else begin : g_link
      assign idx_in  = c_idx[g-1];
      assign dist_in = c_dist[g-1];
    end
    kmnca_cell #(
      .IDX      (g),
      .MAX_DIMS (MAX_DIMS),
      .CW       (CW),
      .CA_W     (CA_W),
      .DA_W     (DA_W)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctl           (ctl),
      .sel           (CA_W'(center_index) == CA_W'(g)),
      .waddr         (DA_W'(dim_index)),
      .raddr         (raddr),
      .wdata         (coord_sat),
      .coord         (coord),
      .num_centers   (num_centers),
      .best_sel      (c_idx[MAX_CENTERS-1]),
      .chain_idx_in  (idx_in),
      .chain_dist_in (dist_in),
      .chain_idx     (c_idx[g]),
      .chain_dist    (c_dist[g]),
      .count         (c_cnt[g])
    );
  end

endmodule
`default_nettype wire

### rtl/core/kmnca_cell.sv
// One centre of the chain: its coordinates, running distance and count.
// Passes the best (index, distance) pair to its neighbour. Uses kmnca_pkg.
`default_nettype none
module kmnca_cell #(
  parameter int IDX      = 0,
  parameter int MAX_DIMS = kmnca_pkg::MAX_DIMS_DEF,
  parameter int CW       = kmnca_pkg::COORD_BITS_DEF,
  parameter int CA_W     = 4,
  parameter int DA_W     = 4
) (
  input  wire                               clk,
  input  wire                               rst,
  input  kmnca_pkg::cell_ctl_t              ctl,
  input  wire                               sel,
  input  wire [DA_W-1:0]                    waddr,
  input  wire [DA_W-1:0]                    raddr,
  input  wire signed [CW-1:0]               wdata,
  input  wire signed [CW-1:0]               coord,
  input  wire [kmnca_pkg::NUM_W-1:0]        num_centers,
  input  wire [CA_W-1:0]                    best_sel,
  input  wire [CA_W-1:0]                    chain_idx_in,
  input  wire [kmnca_pkg::DIST_W-1:0]       chain_dist_in,
  output logic [CA_W-1:0]                   chain_idx,
  output logic [kmnca_pkg::DIST_W-1:0]      chain_dist,
  output logic [kmnca_pkg::CNT_W-1:0]       count
);
  import kmnca_pkg::*;

  localparam int PW = 2 * CW + 2;
  localparam int SW = ((PW > DIST_W) ? PW : DIST_W) + 1;
  localparam logic [SW-1:0] DMAX = SW'({DIST_W{1'b1}});

  logic signed [CW-1:0] mem [MAX_DIMS];
  logic signed [CW-1:0] rd_data;
  logic [PW-1:0]        prod;
  logic [DIST_W-1:0]    part;
  logic signed [CW:0]   diff;
  logic [CW:0]          mag;
  logic [SW-1:0]        sum;
  logic                 in_use;
  logic                 take_own;

  always_ff @(posedge clk) begin
    if (ctl.wr && sel) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
  end

  always_comb begin
    diff = (CW+1)'(coord) - (CW+1)'(rd_data);
    mag  = diff[CW] ? (CW+1)'(-diff) : (CW+1)'(diff);
    sum  = SW'(part) + SW'(prod);
    in_use = (IDX == 0) || (7'(IDX) < 7'(num_centers));
    take_own = (IDX == 0) || (in_use && (part < chain_dist_in));
  end

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod <= PW'(mag) * PW'(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clr_part) begin
      part <= '0;
    end else if (ctl.acc) begin
      part <= (sum > DMAX) ? {DIST_W{1'b1}} : sum[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clr_cnt) begin
      count <= '0;
    end else if (ctl.bump && (best_sel == CA_W'(IDX)) && (count != {CNT_W{1'b1}})) begin
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.chain) begin
      if (take_own) begin
        chain_idx  <= CA_W'(IDX);
        chain_dist <= part;
      end else begin
        chain_idx  <= chain_idx_in;
        chain_dist <= chain_dist_in;
      end
    end
  end

endmodule
`default_nettype wire
